// ----- src/bpl_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bpl_pkg
// Shared types and constants of the brake power limit controller.
// ---------------------------------------------------------------------------
package bpl_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int MAX_POINTS = 16;
	localparam int IDX_W      = 4;

	localparam logic [1:0] CFG_SAMPLE_TIME = 2'd0;
	localparam logic [1:0] CFG_ALARM_LEVEL = 2'd1;
	localparam logic [1:0] CFG_NUM_POINTS  = 2'd2;

	localparam logic [30:0] SAMPLE_TIME_RST = 31'd66;
	localparam logic [3:0]  NUM_POINTS_RST  = 4'd15;

	localparam logic [2:0] MODE_IDLE       = 3'd0;
	localparam logic [2:0] MODE_BRAKE_ON   = 3'd1;
	localparam logic [2:0] MODE_STOP_COUNT = 3'd2;
	localparam logic [2:0] MODE_BRAKE_OFF  = 3'd3;
	localparam logic [2:0] MODE_OFF_SCAN   = 3'd4;
	localparam logic [2:0] MODE_OFF_INTERP = 3'd5;
	localparam logic [2:0] MODE_ON_SCAN    = 3'd6;
	localparam logic [2:0] MODE_ON_INTERP  = 3'd7;

	localparam logic [30:0]        BUDGET_MAX = {31{1'b1}};
	localparam logic signed [47:0] ACC_MAX    = {1'b0, {47{1'b1}}};
	localparam logic signed [47:0] ACC_MIN    = {1'b1, {47{1'b0}}};

	typedef struct packed {
		logic               action;
		logic               reset_request;
		logic               brake_active;
		logic signed [31:0] power_ref;
		logic signed [31:0] power_max_limit;
		logic signed [31:0] power_restore;
		logic               curve_select;
		logic [IDX_W-1:0]   point_index;
		logic [30:0]        point_time;
		logic signed [31:0] point_power;
	} item_t;

	typedef struct packed {
		logic signed [31:0] power_limited;
		logic               alarm;
		logic [30:0]        time_budget;
		logic signed [47:0] integral_limit;
		logic signed [47:0] integral_ref;
		logic [2:0]         mode;
	} result_t;

	typedef struct packed {
		logic [30:0]        ptime;
		logic signed [31:0] ppower;
	} point_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RDA,
		ST_RDB,
		ST_MUL1,
		ST_MUL2,
		ST_FIN,
		ST_DIV,
		ST_OUT
	} seq_state_t;

endpackage

// ----- src/brake_power_limit_controller.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// brake_power_limit_controller
// Per-tick brake power limiter with curve scan and budget interpolation.
// ---------------------------------------------------------------------------
//  channel  | handshake                   | payload
//  ---------+-----------------------------+----------------------
//  request  | item_valid / item_stall     | item   (bpl_pkg::item_t)
//  result   | result_valid / result_stall | result (bpl_pkg::result_t)
//  config   | cfg_we                      | cfg_index, cfg_data
//
//  A load request goes from idle straight to the output state; a tick
//  passes through two curve memory reads, two passes through the shared
//  multiplier, the update and the output. An interpolation tick also waits
//  for the 64 steps of the radix-2 divider to finish.
//  One request is in flight at a time; item_stall is high until the result
//  is taken. A stalled result holds in place. Reset is asynchronous, the
//  curve memory is not cleared.
// ---------------------------------------------------------------------------
module brake_power_limit_controller (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [31:0]      cfg_data,
	input  logic             item_valid,
	output logic             item_stall,
	input  bpl_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_stall,
	output bpl_pkg::result_t result
);
	import bpl_pkg::*;

	seq_state_t state_q, state_d;
	item_t      in_q;
	logic       accept_in;

	logic [30:0]        st_q;
	logic signed [31:0] alarm_level_q;
	logic [3:0]         last_q;

	logic [2:0]         mode_q, mode_n;
	logic [30:0]        budget_q, budget_n;
	logic signed [31:0] limited_q, limited_n;
	logic signed [47:0] lim_acc_q, lim_acc_n;
	logic signed [47:0] ref_acc_q, ref_acc_n;
	logic               alarm_q, alarm_n;
	logic               brake_prev_q, brake_prev_n;
	logic signed [31:0] saved_limit_q, saved_limit_n;
	logic signed [31:0] saved_restore_q, saved_restore_n;
	logic [3:0]         scan_q, scan_n;
	logic [3:0]         scan_prev_q, scan_prev_n;

	point_t      mem_q [0:2*MAX_POINTS-1];
	point_t      rd_data_q;
	point_t      a_q, b_q;
	logic        rd_en;
	logic [4:0]  rd_addr;
	logic        curve_sel;
	logic [3:0]  idx_a;

	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] mul_p;
	logic signed [65:0] p1_q;

	logic               is_interp;
	logic signed [32:0] den;
	logic [32:0]        den_mag;
	logic [63:0]        num_mag;
	logic               q_neg_q;
	logic               div_start, div_busy, div_done;
	logic [63:0]        div_quo;
	logic [30:0]        interp_budget;

	function automatic logic signed [48:0] scaled(input logic signed [65:0] p);
		return p[FRAC_BITS+48:FRAC_BITS];
	endfunction

	function automatic logic signed [47:0] sat_acc(input logic signed [47:0] acc,
		input logic signed [48:0] addend);
		logic signed [48:0] sum;
		sum = {acc[47], acc} + addend;
		if (sum[48] != sum[47]) begin
			return sum[48] ? ACC_MIN : ACC_MAX;
		end
		return sum[47:0];
	endfunction

	assign accept_in    = item_valid && !item_stall;
	assign item_stall   = (state_q != ST_IDLE);
	assign result_valid = (state_q == ST_OUT);

	assign result.power_limited  = limited_q;
	assign result.alarm          = alarm_q;
	assign result.time_budget    = budget_q;
	assign result.integral_limit = lim_acc_q;
	assign result.integral_ref   = ref_acc_q;
	assign result.mode           = mode_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q          <= SAMPLE_TIME_RST;
			alarm_level_q <= '0;
			last_q        <= NUM_POINTS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SAMPLE_TIME: st_q <= cfg_data[30:0];
				CFG_ALARM_LEVEL: alarm_level_q <= cfg_data;
				CFG_NUM_POINTS:  last_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// curve memory: {curve, index}, curve 1 is the brake-off curve
	always_ff @(posedge clk) begin
		if (accept_in && item.action) begin
			mem_q[{item.curve_select, item.point_index}] <= {item.point_time, item.point_power};
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	always_comb begin
		curve_sel = (mode_q == MODE_OFF_SCAN) || (mode_q == MODE_OFF_INTERP);
		case (mode_q)
			MODE_BRAKE_ON, MODE_STOP_COUNT: idx_a = last_q;
			MODE_OFF_SCAN, MODE_OFF_INTERP, MODE_ON_SCAN, MODE_ON_INTERP: idx_a = scan_q;
			default: idx_a = '0;
		endcase
		if (state_q == ST_IDLE && item.reset_request) begin
			idx_a     = '0;
			curve_sel = 1'b0;
		end
		rd_addr = {curve_sel, idx_a};
		if (state_q == ST_RDA) begin
			rd_addr = {curve_sel, scan_prev_q};
		end
		rd_en = (state_q == ST_IDLE && accept_in && !item.action) || (state_q == ST_RDA);
	end

	// multiplier operands: first product in ST_MUL1, second in ST_MUL2
	always_comb begin
		logic signed [31:0] tdiff;
		logic signed [31:0] lvl;
		tdiff = $signed({1'b0, b_q.ptime}) - $signed({1'b0, a_q.ptime});
		lvl   = (mode_q == MODE_OFF_INTERP) ? saved_limit_q : saved_restore_q;
		mul_a = '0;
		mul_b = $signed({2'b00, st_q});
		if (state_q == ST_MUL2) begin
			mul_a = {in_q.power_ref[31], in_q.power_ref};
		end else begin
			case (mode_q)
				MODE_BRAKE_ON:   mul_a = {in_q.power_max_limit[31], in_q.power_max_limit};
				MODE_STOP_COUNT: mul_a = {limited_q[31], limited_q};
				MODE_OFF_INTERP, MODE_ON_INTERP: begin
					mul_a = {tdiff[31], tdiff};
					mul_b = {lvl[31], lvl} - {a_q.ppower[31], a_q.ppower};
				end
				default: mul_a = '0;
			endcase
		end
	end

	bpl_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	// divider operands, magnitudes of product and power difference
	always_comb begin
		logic signed [65:0] neg_p;
		neg_p     = -p1_q;
		is_interp = (mode_q == MODE_OFF_INTERP) || (mode_q == MODE_ON_INTERP);
		den       = {b_q.ppower[31], b_q.ppower} - {a_q.ppower[31], a_q.ppower};
		den_mag   = den[32] ? 33'(-den) : den;
		num_mag   = p1_q[65] ? neg_p[63:0] : p1_q[63:0];
		div_start = (state_q == ST_FIN) && !in_q.reset_request && is_interp && (den != '0);
	end

	bpl_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (num_mag),
		.divisor  (den_mag),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_comb begin
		logic signed [65:0] qs;
		logic signed [65:0] sum;
		qs  = q_neg_q ? -$signed({2'b00, div_quo}) : $signed({2'b00, div_quo});
		sum = qs + $signed({35'd0, a_q.ptime});
		if (sum < 0) begin
			interp_budget = '0;
		end else if (sum > $signed({35'd0, BUDGET_MAX})) begin
			interp_budget = BUDGET_MAX;
		end else begin
			interp_budget = sum[30:0];
		end
	end

	// tick update
	always_comb begin
		logic               falling;
		logic [31:0]        bud_sum;
		logic [30:0]        bud_acc;
		logic [30:0]        bud;
		logic signed [32:0] bud_dec;
		logic signed [48:0] sc1, sc2;
		logic signed [47:0] base_lim, base_ref, ref_tmp;
		logic signed [31:0] lim_tmp, lvl;
		logic signed [31:0] pmax, pref, prest;
		logic [30:0]        cap;

		pmax    = in_q.power_max_limit;
		pref    = in_q.power_ref;
		prest   = in_q.power_restore;
		cap     = a_q.ptime;
		falling = brake_prev_q && !in_q.brake_active;
		bud_sum = {1'b0, budget_q} + {1'b0, st_q};
		bud_acc = bud_sum[31] ? BUDGET_MAX : bud_sum[30:0];
		bud_dec = $signed({2'b00, budget_q}) - $signed({2'b00, st_q});
		sc1     = scaled(p1_q);
		sc2     = scaled(mul_p);
		lvl     = (mode_q == MODE_OFF_SCAN) ? saved_limit_q : saved_restore_q;
		bud     = budget_q;
		lim_tmp = limited_q;
		ref_tmp = ref_acc_q;
		base_lim = lim_acc_q;
		base_ref = ref_acc_q;

		mode_n          = mode_q;
		budget_n        = budget_q;
		limited_n       = limited_q;
		lim_acc_n       = lim_acc_q;
		ref_acc_n       = ref_acc_q;
		alarm_n         = alarm_q;
		saved_limit_n   = saved_limit_q;
		saved_restore_n = saved_restore_q;
		scan_n          = scan_q;
		scan_prev_n     = scan_prev_q;
		brake_prev_n    = in_q.reset_request ? brake_prev_q : in_q.brake_active;

		if (in_q.reset_request) begin
			budget_n  = '0;
			limited_n = a_q.ppower;
			lim_acc_n = '0;
			ref_acc_n = '0;
			alarm_n   = 1'b0;
			mode_n    = MODE_IDLE;
		end else begin
			case (mode_q)
				MODE_IDLE: begin
					limited_n       = a_q.ppower;
					alarm_n         = 1'b0;
					saved_restore_n = '0;
					saved_limit_n   = '0;
					if (in_q.brake_active) begin
						mode_n = MODE_BRAKE_ON;
					end
				end
				MODE_BRAKE_ON: begin
					saved_limit_n = '0;
					if (falling) begin
						mode_n        = MODE_OFF_SCAN;
						scan_n        = '0;
						saved_limit_n = pmax;
						base_lim      = '0;
						base_ref      = '0;
					end
					budget_n  = (bud_acc >= cap) ? cap : bud_acc;
					limited_n = pmax;
					lim_acc_n = base_lim;
					ref_acc_n = base_ref;
					if (pref > a_q.ppower) begin
						lim_acc_n = sat_acc(base_lim, sc1);
						ref_acc_n = sat_acc(base_ref, sc2);
					end
					if (pmax <= pref) begin
						mode_n = MODE_STOP_COUNT;
					end
					alarm_n = (pmax <= alarm_level_q);
				end
				MODE_STOP_COUNT: begin
					ref_tmp = sat_acc(ref_acc_q, sc1);
					if (ref_tmp >= lim_acc_q) begin
						bud     = bud_acc;
						lim_tmp = pmax;
					end
					budget_n  = (bud >= cap) ? cap : bud;
					ref_acc_n = ref_tmp;
					limited_n = lim_tmp;
					if (falling) begin
						mode_n        = MODE_OFF_SCAN;
						scan_n        = '0;
						saved_limit_n = pmax;
						lim_acc_n     = '0;
						ref_acc_n     = '0;
					end
					alarm_n = (lim_tmp <= alarm_level_q);
				end
				MODE_BRAKE_OFF: begin
					saved_restore_n = '0;
					limited_n       = prest;
					if (bud_dec <= 0) begin
						mode_n   = MODE_IDLE;
						budget_n = '0;
					end else begin
						budget_n = bud_dec[30:0];
					end
					if (in_q.brake_active) begin
						mode_n          = MODE_ON_SCAN;
						scan_n          = '0;
						lim_acc_n       = '0;
						ref_acc_n       = '0;
						saved_restore_n = prest;
					end
					alarm_n = (prest <= alarm_level_q);
				end
				MODE_OFF_SCAN, MODE_ON_SCAN: begin
					if (lvl <= a_q.ppower && scan_q < last_q) begin
						scan_n = scan_q + 4'd1;
					end else begin
						// a stop at point zero uses the first segment
						if (scan_q == '0) begin
							scan_n      = 4'd1;
							scan_prev_n = '0;
						end else begin
							scan_prev_n = scan_q - 4'd1;
						end
						mode_n = (mode_q == MODE_OFF_SCAN) ? MODE_OFF_INTERP : MODE_ON_INTERP;
					end
				end
				MODE_OFF_INTERP: mode_n = MODE_BRAKE_OFF;
				MODE_ON_INTERP:  mode_n = MODE_BRAKE_ON;
				default: mode_n = mode_q;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept_in) begin
					state_d = item.action ? ST_OUT : ST_RDA;
				end
			end
			ST_RDA:  state_d = ST_RDB;
			ST_RDB:  state_d = ST_MUL1;
			ST_MUL1: state_d = ST_MUL2;
			ST_MUL2: state_d = ST_FIN;
			ST_FIN:  state_d = div_start ? ST_DIV : ST_OUT;
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (!result_stall) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept_in) begin
			in_q <= item;
		end
		if (state_q == ST_RDA) begin
			a_q <= rd_data_q;
		end
		if (state_q == ST_RDB) begin
			b_q <= rd_data_q;
		end
		if (state_q == ST_MUL2) begin
			p1_q <= mul_p;
		end
		if (state_q == ST_FIN) begin
			q_neg_q <= p1_q[65] ^ den[32];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q          <= MODE_IDLE;
			budget_q        <= '0;
			limited_q       <= '0;
			lim_acc_q       <= '0;
			ref_acc_q       <= '0;
			alarm_q         <= 1'b0;
			brake_prev_q    <= 1'b0;
			saved_limit_q   <= '0;
			saved_restore_q <= '0;
			scan_q          <= '0;
			scan_prev_q     <= '0;
		end else if (state_q == ST_FIN) begin
			mode_q          <= mode_n;
			budget_q        <= budget_n;
			limited_q       <= limited_n;
			lim_acc_q       <= lim_acc_n;
			ref_acc_q       <= ref_acc_n;
			alarm_q         <= alarm_n;
			brake_prev_q    <= brake_prev_n;
			saved_limit_q   <= saved_limit_n;
			saved_restore_q <= saved_restore_n;
			scan_q          <= scan_n;
			scan_prev_q     <= scan_prev_n;
		end else if (state_q == ST_DIV && div_done) begin
			budget_q <= interp_budget;
		end
	end

	a_busy_out: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> item_stall)
		else $error("result shown while requests are open");

	a_div_owned: assert property (@(posedge clk) disable iff (!arst_n)
		div_busy |-> (state_q == ST_DIV))
		else $error("divider running outside its wait state");

	a_reset_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && in_q.reset_request) |=> (mode_q == MODE_IDLE))
		else $error("reset request did not return to idle");

	a_segment: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_OFF_INTERP || mode_q == MODE_ON_INTERP) |-> (scan_prev_q < scan_q))
		else $error("interpolation segment out of order");

endmodule

// ----- src/bpl_mul.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bpl_mul
// Shared signed 33x33 multiplier with a registered product.
// ---------------------------------------------------------------------------
module bpl_mul (
	input  logic               clk,
	input  logic signed [32:0] a,
	input  logic signed [32:0] b,
	output logic signed [65:0] p
);
	always_ff @(posedge clk) begin
		p <= a * b;
	end
endmodule

// ----- src/bpl_div.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bpl_div
// Radix-2 restoring divider, unsigned 64 by 33 bits, one quotient bit a cycle.
// ---------------------------------------------------------------------------
module bpl_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [32:0] divisor,
	output logic        busy,
	output logic        done,
	output logic [63:0] quotient
);
	localparam logic [6:0] STEPS = 7'd64;

	logic        busy_q;
	logic        done_q;
	logic [6:0]  cnt_q;
	logic [63:0] quo_q;
	logic [32:0] rem_q;
	logic [32:0] div_q;
	logic [33:0] rem_sh;
	logic [34:0] diff;

	assign rem_sh = {rem_q, quo_q[63]};
	assign diff   = {1'b0, rem_sh} - {2'b00, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= STEPS;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			// keep the difference when it did not go negative
			quo_q <= {quo_q[62:0], ~diff[34]};
			rem_q <= diff[34] ? rem_sh[32:0] : diff[32:0];
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;
endmodule

// ----- test/brake_power_limit_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// brake_power_limit_checker
// Watches the request, result and register ports of the brake power limit
// controller, runs its own per-tick model of the limiter and compares every
// result field with the oldest expected one.
// ---------------------------------------------------------------------------
module brake_power_limit_checker (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [31:0]      cfg_data,
	input  logic             item_valid,
	input  logic             item_stall,
	input  bpl_pkg::item_t   item,
	input  logic             result_valid,
	input  logic             result_stall,
	input  bpl_pkg::result_t result,
	output int               errors,
	output int               pending,
	output int               ticks,
	output int               loads
);
	import bpl_pkg::*;

	logic [30:0]        tick_period;
	logic signed [31:0] alarm_lvl;
	logic [3:0]         last_point;

	logic [2:0] mode_q;
	longint     budget, lim_power, int_lim, int_ref, keep_limit, keep_restore;
	bit         alarm_q, brake_q;
	int         scan_i, scan_j;
	longint     on_t[MAX_POINTS], on_p[MAX_POINTS], off_t[MAX_POINTS], off_p[MAX_POINTS];

	result_t expected_results[$];

	function automatic longint scale_power(longint p);
		return (p * longint'(tick_period)) >>> FRAC_BITS;
	endfunction

	function automatic longint sat_add(longint a, longint b);
		longint s;
		s = a + b;
		if (s > longint'(ACC_MAX))
			return longint'(ACC_MAX);
		if (s < longint'(ACC_MIN))
			return longint'(ACC_MIN);
		return s;
	endfunction

	function automatic longint clamp_budget(longint b);
		if (b < 0)
			return 0;
		if (b > longint'(BUDGET_MAX))
			return longint'(BUDGET_MAX);
		return b;
	endfunction

	task automatic cap_budget();
		if (budget >= on_t[last_point])
			budget = clamp_budget(on_t[last_point]);
	endtask

	task automatic begin_release(longint pmax);
		mode_q = MODE_OFF_SCAN;
		scan_i = 0;
		keep_limit = pmax;
		int_lim = 0;
		int_ref = 0;
	endtask

	task automatic scan_curve(bit off_curve, longint level, logic [2:0] next_mode);
		longint pw;
		pw = off_curve ? off_p[scan_i] : on_p[scan_i];
		if (level <= pw && scan_i < int'(last_point)) begin
			scan_i = scan_i + 1;
		end else begin
			if (scan_i == 0) begin
				scan_i = 1;
				scan_j = 0;
			end else begin
				scan_j = scan_i - 1;
			end
			mode_q = next_mode;
		end
	endtask

	task automatic interp_budget(bit off_curve, longint level);
		logic signed [95:0] ti, tj, pi, pj, num, den;
		ti = off_curve ? off_t[scan_i] : on_t[scan_i];
		tj = off_curve ? off_t[scan_j] : on_t[scan_j];
		pi = off_curve ? off_p[scan_i] : on_p[scan_i];
		pj = off_curve ? off_p[scan_j] : on_p[scan_j];
		den = pj - pi;
		if (den != 0) begin
			num = (tj - ti) * (96'(signed'(level)) - pi);
			num = num / den + ti;
			if (num < 0)
				budget = 0;
			else if (num > 96'(longint'(BUDGET_MAX)))
				budget = longint'(BUDGET_MAX);
			else
				budget = longint'(num);
		end
	endtask

	task automatic predict_request(item_t it);
		longint  pref, pmax, prest;
		bit      falling;
		result_t r;
		pref = it.power_ref;
		pmax = it.power_max_limit;
		prest = it.power_restore;
		falling = brake_q && !it.brake_active;
		if (it.action) begin
			loads++;
			if (it.curve_select) begin
				off_t[it.point_index] = it.point_time;
				off_p[it.point_index] = it.point_power;
			end else begin
				on_t[it.point_index] = it.point_time;
				on_p[it.point_index] = it.point_power;
			end
		end else if (it.reset_request) begin
			ticks++;
			budget = 0;
			lim_power = on_p[0];
			int_lim = 0;
			int_ref = 0;
			alarm_q = 0;
			mode_q = MODE_IDLE;
		end else begin
			ticks++;
			case (mode_q)
				MODE_IDLE: begin
					lim_power = on_p[0];
					alarm_q = 0;
					keep_restore = 0;
					keep_limit = 0;
					if (it.brake_active)
						mode_q = MODE_BRAKE_ON;
				end
				MODE_BRAKE_ON: begin
					keep_limit = 0;
					if (falling)
						begin_release(pmax);
					budget = clamp_budget(budget + longint'(tick_period));
					cap_budget();
					lim_power = pmax;
					if (pref > on_p[last_point]) begin
						int_lim = sat_add(int_lim, scale_power(pmax));
						int_ref = sat_add(int_ref, scale_power(pref));
					end
					if (pmax <= pref)
						mode_q = MODE_STOP_COUNT;
					alarm_q = lim_power <= alarm_lvl;
				end
				MODE_STOP_COUNT: begin
					int_ref = sat_add(int_ref, scale_power(lim_power));
					if (int_ref >= int_lim) begin
						budget = clamp_budget(budget + longint'(tick_period));
						lim_power = pmax;
					end
					cap_budget();
					if (falling)
						begin_release(pmax);
					alarm_q = lim_power <= alarm_lvl;
				end
				MODE_BRAKE_OFF: begin
					keep_restore = 0;
					budget = budget - longint'(tick_period);
					lim_power = prest;
					if (budget <= 0) begin
						mode_q = MODE_IDLE;
						budget = 0;
					end
					if (it.brake_active) begin
						mode_q = MODE_ON_SCAN;
						scan_i = 0;
						int_lim = 0;
						int_ref = 0;
						keep_restore = prest;
					end
					alarm_q = lim_power <= alarm_lvl;
				end
				MODE_OFF_SCAN: scan_curve(1, keep_limit, MODE_OFF_INTERP);
				MODE_OFF_INTERP: begin
					interp_budget(1, keep_limit);
					mode_q = MODE_BRAKE_OFF;
				end
				MODE_ON_SCAN: scan_curve(0, keep_restore, MODE_ON_INTERP);
				default: begin
					interp_budget(0, keep_restore);
					mode_q = MODE_BRAKE_ON;
				end
			endcase
			brake_q = it.brake_active;
		end
		r.power_limited = lim_power[31:0];
		r.alarm = alarm_q;
		r.time_budget = budget[30:0];
		r.integral_limit = int_lim[47:0];
		r.integral_ref = int_ref[47:0];
		r.mode = mode_q;
		expected_results.push_back(r);
	endtask

	task automatic compare_result(result_t act);
		result_t exp;
		if (expected_results.size() == 0) begin
			$error("result with no request outstanding");
			errors++;
			return;
		end
		exp = expected_results.pop_front();
		if (act.power_limited !== exp.power_limited) begin
			$error("power_limited exp %0d act %0d", exp.power_limited, act.power_limited);
			errors++;
		end
		if (act.alarm !== exp.alarm) begin
			$error("alarm exp %0d act %0d", exp.alarm, act.alarm);
			errors++;
		end
		if (act.time_budget !== exp.time_budget) begin
			$error("time_budget exp %0d act %0d", exp.time_budget, act.time_budget);
			errors++;
		end
		if (act.integral_limit !== exp.integral_limit) begin
			$error("integral_limit exp %0d act %0d", exp.integral_limit, act.integral_limit);
			errors++;
		end
		if (act.integral_ref !== exp.integral_ref) begin
			$error("integral_ref exp %0d act %0d", exp.integral_ref, act.integral_ref);
			errors++;
		end
		if (act.mode !== exp.mode) begin
			$error("mode exp %0d act %0d", exp.mode, act.mode);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			errors = 0;
			ticks = 0;
			loads = 0;
			pending = 0;
			tick_period = SAMPLE_TIME_RST;
			alarm_lvl = 0;
			last_point = NUM_POINTS_RST;
			mode_q = MODE_IDLE;
			budget = 0;
			lim_power = 0;
			int_lim = 0;
			int_ref = 0;
			alarm_q = 0;
			brake_q = 0;
			keep_limit = 0;
			keep_restore = 0;
			scan_i = 0;
			scan_j = 0;
			expected_results.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_SAMPLE_TIME: tick_period = cfg_data[30:0];
					CFG_ALARM_LEVEL: alarm_lvl = cfg_data;
					CFG_NUM_POINTS:  last_point = cfg_data[3:0];
					default: ;
				endcase
			end
			// results first: the result taken now belongs to an earlier request
			if (result_valid && !result_stall)
				compare_result(result);
			if (item_valid && !item_stall)
				predict_request(item);
			pending = expected_results.size();
		end
	end

endmodule

// ----- test/brake_power_limit_controller_test.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// brake_power_limit_controller_test
// Drives brake episodes, curve loads, reset requests and noise into the
// limiter under several register settings and random idling on both sides;
// a separate checker predicts and compares every result.
// ---------------------------------------------------------------------------
module brake_power_limit_controller_test;
	import bpl_pkg::*;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_we = 0;
	logic [1:0]  cfg_index = CFG_SAMPLE_TIME;
	logic [31:0] cfg_data = 0;
	logic        item_valid = 0;
	logic        item_stall;
	item_t       item = '0;
	logic        result_valid;
	logic        result_stall = 0;
	result_t     result;

	int errors, pending, ticks, loads;
	int send_idle_pct, recv_idle_pct, sent;
	int long_hold = 0;
	int hold_seen = 0;
	int hold_reqs = 0;

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	brake_power_limit_controller dut (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.item_valid, .item_stall, .item,
		.result_valid, .result_stall, .result
	);

	brake_power_limit_checker checker_i (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.item_valid, .item_stall, .item,
		.result_valid, .result_stall, .result,
		.errors, .pending, .ticks, .loads
	);

	// receiver: random stalls plus one long hold-off
	always @(posedge clk) begin
		if (hold_seen != hold_reqs) begin
			hold_seen = hold_reqs;
			long_hold = 300;
		end
		if (long_hold > 0) begin
			long_hold--;
			result_stall <= 1;
		end else begin
			result_stall <= $urandom_range(99) < recv_idle_pct;
		end
	end

	function automatic logic [31:0] any_word();
		case ($urandom_range(7))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 0;
			3: return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic signed [31:0] mid_power();
		return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
	endfunction

	function automatic item_t noise_item();
		item_t       it;
		logic [191:0] raw;
		raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		it = raw[$bits(item_t)-1:0];
		it.power_ref = any_word();
		it.power_max_limit = any_word();
		it.power_restore = any_word();
		it.point_power = any_word();
		return it;
	endfunction

	task automatic send(item_t it);
		if ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		item <= it;
		item_valid <= 1;
		do @(posedge clk); while (item_stall);
		sent++;
	endtask

	task automatic load_point(bit off_curve, int idx, logic [30:0] t, logic [31:0] p);
		item_t it;
		it = noise_item();
		it.action = 1;
		it.curve_select = off_curve;
		it.point_index = 4'(idx);
		it.point_time = t;
		it.point_power = p;
		send(it);
	endtask

	task automatic tick(bit brake, bit rst, logic [31:0] pref, logic [31:0] pmax,
			logic [31:0] prest);
		item_t it;
		it = noise_item();
		it.action = 0;
		it.reset_request = rst;
		it.brake_active = brake;
		it.power_ref = pref;
		it.power_max_limit = pmax;
		it.power_restore = prest;
		send(it);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] data);
		item_valid <= 0;
		// let the checker count the last accepted request first
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 0;
	endtask

	// powers that never rise above point zero's so the scan walks into the curve
	task automatic load_curves(bit wide);
		int i;
		logic [30:0] t;
		for (i = 0; i < MAX_POINTS; i++) begin
			t = wide ? $urandom : 31'(i * $urandom_range(1, 32'h1_0000));
			load_point(0, i, t, 32'sh0010_0000 - i * $urandom_range(1, 32'h2_0000));
			load_point(1, i, t, 32'sh0010_0000 - i * $urandom_range(0, 32'h2_0000));
		end
	endtask

	task automatic brake_episode();
		int i, n_on, n_off, reapply;
		logic [31:0] pref, pmax;
		bit wild;
		wild = $urandom_range(9) == 0;
		n_on = $urandom_range(1, 8);
		n_off = $urandom_range(1, 25);
		reapply = $urandom_range(99) < 25 ? $urandom_range(1, n_off) : 0;
		for (i = 0; i < n_on; i++) begin
			pref = wild ? any_word() : mid_power();
			pmax = wild ? any_word() : mid_power();
			tick(1, 0, pref, pmax, wild ? any_word() : mid_power());
		end
		for (i = 1; i <= n_off; i++)
			tick(i == reapply, 0, mid_power(), mid_power(),
				wild ? any_word() : mid_power());
	endtask

	initial begin
		int ph, target;
		send_idle_pct = 20;
		recv_idle_pct = 57;
		sent = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: curves first so no unwritten point is ever read
		for (int i = 0; i < MAX_POINTS; i++) begin
			load_point(0, i, i == 15 ? 31'h7fff_ffff : 31'(i * 32'h4_0000),
				i == 0 ? 32'h7fff_ffff : 32'sh0010_0000 - i * 32'h1_0000);
			load_point(1, i, i == 0 ? 31'd0 : 31'(i * 32'h3_0000),
				i == 15 ? 32'h8000_0000 : 32'sh0010_0000 - i * 32'h1_0000);
		end
		tick(0, 0, 0, 0, 0);
		tick(1, 0, 32'h7fff_ffff, 32'h8000_0000, 0);
		tick(1, 0, 32'h7fff_ffff, 32'h8000_0000, 0);
		tick(0, 0, 32'h0001_0000, 32'h0002_0000, 32'h8000_0000);
		for (int i = 0; i < 18; i++)
			tick(i == 17, 0, 32'h0002_0000, 32'h0001_0000, 32'h7fff_ffff);
		tick(1, 1, 0, 0, 0);
		tick(1, 0, 32'h8000_0000, 32'h7fff_ffff, 0);
		tick(0, 0, 0, 32'h7fff_ffff, 0);
		for (int i = 0; i < 20; i++)
			tick(0, 0, 0, 0, 32'h0000_1000);

		for (ph = 0; ph < 8; ph++) begin
			send_idle_pct = ph < 3 ? 20 : (ph < 6 ? 57 : 0);
			recv_idle_pct = ph < 3 ? 57 : (ph < 6 ? 20 : 0);
			case (ph)
				0: begin
					write_reg(CFG_SAMPLE_TIME, 32'h0000_4000);
					write_reg(CFG_NUM_POINTS, 15);
					write_reg(CFG_ALARM_LEVEL, 0);
				end
				1: begin
					write_reg(CFG_SAMPLE_TIME, 32'h7fff_ffff);
					write_reg(CFG_NUM_POINTS, 0);
					write_reg(CFG_ALARM_LEVEL, 32'h7fff_ffff);
				end
				2: begin
					write_reg(CFG_SAMPLE_TIME, 1);
					write_reg(CFG_NUM_POINTS, 1);
					write_reg(CFG_ALARM_LEVEL, 32'h8000_0000);
				end
				default: begin
					write_reg(CFG_SAMPLE_TIME, $urandom_range(32'h1000, 32'h4_0000));
					write_reg(CFG_NUM_POINTS, $urandom_range(0, 15));
					write_reg(CFG_ALARM_LEVEL, mid_power());
				end
			endcase
			if (ph == 4)
				load_curves(1);
			target = sent + 95;
			if (ph == 1)
				hold_reqs++;
			while (sent < target) begin
				case ($urandom_range(19))
					0: send(noise_item());
					1: load_point($urandom_range(1), $urandom_range(15), $urandom,
						$urandom_range(1) ? any_word() : mid_power());
					2: tick($urandom_range(1), 1, mid_power(), mid_power(), mid_power());
					default: brake_episode();
				endcase
			end
			if (ph == 4)
				load_curves(0);
		end

		item_valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		$display("covered %0d ticks and %0d curve loads over 8 register settings,", ticks, loads);
		$display("with sender and receiver idling swapped and one long result hold-off");
		if (errors == 0)
			$display("** brake_power_limit_controller: PASSED **");
		else
			$display("** brake_power_limit_controller: FAILED **");
		$finish;
	end

	initial begin
		#20ms;
		$display("** brake_power_limit_controller: FAILED **");
		$finish;
	end

endmodule
